// ----- src/bnlkm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnlkm_pkg: shared types and constants of the key match unit
// Operation codes, key type codes, register indexes and the row token that
// travels down the compare chain.
// ----------------------------------------------------------------------------
package bnlkm_pkg;

  localparam int KEY_W          = 64;
  localparam int ROW_W          = 6;
  localparam int NUM_KEY_PORTS  = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int DEF_NUM_ROWS   = 64;
  localparam int DEF_MAX_KEYS   = 4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PROBE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KT_INT32  = 2'd0,
    KT_INT64  = 2'd1,
    KT_DOUBLE = 2'd2,
    KT_RAW    = 2'd3
  } key_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEYS_IN_USE = 2'd0,
    CFG_KEY_TYPES   = 2'd1
  } cfg_reg_t;

  // One row slot moving down the chain; eos marks the end of a probe scan.
  typedef struct packed {
    logic             vld;
    logic             eos;
    logic [ROW_W-1:0] row;
    logic             match;
  } tok_t;

endpackage

// ----- src/bnlkm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnlkm_ram: generic simple dual port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module bnlkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/bnlkm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnlkm_cell: one key column of the compare chain
// Holds the stored column of the block and the probe key, reads the stored
// key of the incoming row token and narrows its match flag.
// ----------------------------------------------------------------------------
module bnlkm_cell
  import bnlkm_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_ROWS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     key_en,
  input  logic [1:0]               key_type,
  input  logic                     probe_ld,
  input  logic [KEY_W-1:0]         probe_key,
  input  logic                     probe_null,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [KEY_W-1:0]         wr_key,
  input  logic                     wr_null,
  input  tok_t                     tok_in,
  output tok_t                     tok_out
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [KEY_W-1:0] probe_key_r;
  logic             probe_null_r;
  tok_t             tok_d_r;
  tok_t             tok_q_r;
  tok_t             tok_q_nxt;
  logic [KEY_W:0]   stored;
  logic             eq;

  bnlkm_ram #(
    .WIDTH (KEY_W + 1),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({wr_null, wr_key}),
    .rd_en   (adv),
    .rd_addr (tok_in.row[ADDR_W-1:0]),
    .rd_data (stored)
  );

  always_ff @(posedge clk) begin
    if (probe_ld) begin
      probe_key_r  <= probe_key;
      probe_null_r <= probe_null;
    end
  end

  always_comb begin
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic             nan_a;
    logic             nan_b;
    a     = stored[KEY_W-1:0];
    b     = probe_key_r;
    nan_a = (&a[62:52]) && (|a[51:0]);
    nan_b = (&b[62:52]) && (|b[51:0]);
    case (key_type)
      KT_INT32: begin
        eq = (a[31:0] == b[31:0]);
      end
      KT_DOUBLE: begin
        if (nan_a || nan_b) begin
          eq = 1'b0;
        end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
          eq = 1'b1;
        end else begin
          eq = (a == b);
        end
      end
      default: begin
        eq = (a == b);
      end
    endcase
  end

  // Narrow the match only for columns in use; a null on either side fails.
  always_comb begin
    tok_q_nxt = tok_d_r;
    if (key_en) begin
      tok_q_nxt.match = tok_d_r.match && eq && !stored[KEY_W] && !probe_null_r;
    end
  end

  // Only the valid bits are reset; the rest of each token just follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_d_r.vld <= 1'b0;
      tok_q_r.vld <= 1'b0;
    end else if (adv) begin
      tok_d_r <= tok_in;
      tok_q_r <= tok_q_nxt;
    end
  end

  assign tok_out = tok_q_r;

endmodule

// ----- src/bnlkm_collect.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnlkm_collect: result stage at the end of the compare chain
// Holds back one match so the final result of a probe can carry last, and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module bnlkm_collect
  import bnlkm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tok_t             tok_in,
  input  logic             out_stall,
  output logic             adv,
  output logic             done,
  output logic             out_valid,
  output logic [ROW_W-1:0] out_outer_row,
  output logic             out_hit,
  output logic             out_last
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ROW_W-1:0] out_row_r;
  logic [ROW_W-1:0] out_row_nxt;
  logic             out_hit_r;
  logic             out_hit_nxt;
  logic             out_last_r;
  logic             out_last_nxt;
  logic             pend_vld_r;
  logic             pend_vld_nxt;
  logic [ROW_W-1:0] pend_row_r;
  logic [ROW_W-1:0] pend_row_nxt;

  // Advance whenever the result register is free or being taken.
  assign adv  = !out_valid_r || !out_stall;
  assign done = adv && tok_in.vld && tok_in.eos;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_hit_nxt   = out_hit_r;
    out_last_nxt  = out_last_r;
    pend_vld_nxt  = pend_vld_r;
    pend_row_nxt  = pend_row_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (tok_in.vld && tok_in.eos) begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = pend_vld_r ? pend_row_r : '0;
        out_hit_nxt   = pend_vld_r;
        out_last_nxt  = 1'b1;
        pend_vld_nxt  = 1'b0;
      end else if (tok_in.vld && tok_in.match) begin
        out_valid_nxt = pend_vld_r;
        out_row_nxt   = pend_row_r;
        out_hit_nxt   = 1'b1;
        out_last_nxt  = 1'b0;
        pend_vld_nxt  = 1'b1;
        pend_row_nxt  = tok_in.row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r  <= out_row_nxt;
    out_hit_r  <= out_hit_nxt;
    out_last_r <= out_last_nxt;
    pend_row_r <= pend_row_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_outer_row = out_row_r;
  assign out_hit       = out_hit_r;
  assign out_last      = out_last_r;

endmodule

// ----- src/block_nested_loop_key_match_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_nested_loop_key_match_unit: equality join over one block of rows
// Stores up to NUM_ROWS outer rows of MAX_KEYS keys and matches a probe row
// against them, one stored row per cycle unless stalled, through a chain of key cells.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | operation, key_0..3, null mask
//  out_    | output    | out_valid/out_stall| outer_row, hit, last
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
//  Clear and load transactions never stall the input channel. A probe holds it
//  until its end token reaches the result stage: the sequencer issues one row
//  token per advancing cycle plus an end token, and every key cell registers
//  the token in its RAM read and compare stages. Reset (rst_n low, synchronous)
//  empties the block and restores keys_in_use = 1 and all key types int32; the
//  RAMs are not cleared. A stall on the result channel freezes the whole chain.
//
module block_nested_loop_key_match_unit
  import bnlkm_pkg::*;
#(
  parameter int NUM_ROWS = DEF_NUM_ROWS,
  parameter int MAX_KEYS = DEF_MAX_KEYS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [KEY_W-1:0]      in_key_0,
  input  logic [KEY_W-1:0]      in_key_1,
  input  logic [KEY_W-1:0]      in_key_2,
  input  logic [KEY_W-1:0]      in_key_3,
  input  logic [3:0]            in_key_null_mask,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_W-1:0]      out_outer_row,
  output logic                  out_hit,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(NUM_ROWS);
  localparam int CNT_W  = $clog2(NUM_ROWS + 1);

  logic [2:0]       keys_in_use_r;
  logic [7:0]       key_types_r;
  logic [2:0]       nk_eff;
  logic [CNT_W-1:0] row_count_r;
  logic [CNT_W-1:0] row_count_nxt;
  logic             busy_r;
  logic             busy_nxt;
  logic             issue_r;
  logic             issue_nxt;
  logic [CNT_W-1:0] ctr_r;
  logic [CNT_W-1:0] ctr_nxt;
  tok_t             seq_tok_r;
  tok_t             seq_tok_nxt;
  logic             in_acc;
  logic             do_load;
  logic             do_probe;
  logic             adv;
  logic             done;
  logic [KEY_W-1:0] in_keys [NUM_KEY_PORTS];
  tok_t             chain [MAX_KEYS+1];

  assign in_keys[0] = in_key_0;
  assign in_keys[1] = in_key_1;
  assign in_keys[2] = in_key_2;
  assign in_keys[3] = in_key_3;

  // Configuration: always ready; the user must write it only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_in_use_r <= 3'd1;
      key_types_r   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_KEYS_IN_USE) begin
        keys_in_use_r <= cfg_wdata[2:0];
      end else if (cfg_index == CFG_KEY_TYPES) begin
        key_types_r <= cfg_wdata;
      end
    end
  end

  // Clamp the column count: zero counts as one, the top at MAX_KEYS.
  always_comb begin
    if (keys_in_use_r == 3'd0) begin
      nk_eff = 3'd1;
    end else if (keys_in_use_r > 3'(MAX_KEYS)) begin
      nk_eff = 3'(MAX_KEYS);
    end else begin
      nk_eff = keys_in_use_r;
    end
  end

  // Input side: hold the channel for the whole length of a probe.
  assign in_stall = busy_r;
  assign in_acc   = in_valid && !in_stall;
  assign do_load  = in_acc && (in_operation == OP_LOAD) &&
                    (row_count_r < CNT_W'(NUM_ROWS));
  assign do_probe = in_acc && (in_operation == OP_PROBE);

  // Sequencer: issue one row token per advancing cycle, then an end token.
  always_comb begin
    row_count_nxt = row_count_r;
    busy_nxt      = busy_r;
    issue_nxt     = issue_r;
    ctr_nxt       = ctr_r;
    seq_tok_nxt   = seq_tok_r;

    if (in_acc && (in_operation == OP_CLEAR)) begin
      row_count_nxt = '0;
    end
    if (do_load) begin
      row_count_nxt = row_count_r + CNT_W'(1);
    end
    if (do_probe) begin
      busy_nxt  = 1'b1;
      issue_nxt = 1'b1;
      ctr_nxt   = '0;
    end

    if (adv) begin
      seq_tok_nxt     = '0;
      seq_tok_nxt.row = ROW_W'(ctr_r);
      if (issue_r) begin
        seq_tok_nxt.vld   = 1'b1;
        seq_tok_nxt.match = 1'b1;
        if (ctr_r < row_count_r) begin
          ctr_nxt = ctr_r + CNT_W'(1);
        end else begin
          seq_tok_nxt.eos = 1'b1;
          issue_nxt       = 1'b0;
        end
      end
    end

    // Drop busy once the end token has reached the result stage.
    if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= '0;
      busy_r        <= 1'b0;
      issue_r       <= 1'b0;
      seq_tok_r.vld <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      busy_r      <= busy_nxt;
      issue_r     <= issue_nxt;
      seq_tok_r   <= seq_tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r <= ctr_nxt;
  end

  assign chain[0] = seq_tok_r;

  // Compare chain: cell k owns key column k of every stored row.
  for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
    bnlkm_cell #(
      .DEPTH (NUM_ROWS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .key_en     (3'(k) < nk_eff),
      .key_type   (key_types_r[2*k+1:2*k]),
      .probe_ld   (do_probe),
      .probe_key  (in_keys[k]),
      .probe_null (in_key_null_mask[k]),
      .wr_en      (do_load),
      .wr_addr    (row_count_r[ADDR_W-1:0]),
      .wr_key     (in_keys[k]),
      .wr_null    (in_key_null_mask[k]),
      .tok_in     (chain[k]),
      .tok_out    (chain[k+1])
    );
  end

  bnlkm_collect u_collect (
    .clk           (clk),
    .rst_n         (rst_n),
    .tok_in        (chain[MAX_KEYS]),
    .out_stall     (out_stall),
    .adv           (adv),
    .done          (done),
    .out_valid     (out_valid),
    .out_outer_row (out_outer_row),
    .out_hit       (out_hit),
    .out_last      (out_last)
  );

endmodule
